FILE: hdl/rgbsp_pkg.sv
package rgbsp_pkg;

  localparam int COLOR_W = 24;
  localparam int DUR_W   = 32;
  localparam int IDX_W   = 4;
  localparam int LEN_W   = 5;
  localparam int REP_W   = 16;
  localparam int DUTY_W  = 8;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'hFF;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_START = 2'd2,
    CMD_SOLID = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_LOAD0,
    ST_DONE
  } state_t;

  // register index 0 sits at byte address 0; paddr[2] selects the register
  localparam logic REG_COMMON_ANODE = 1'b0;

  typedef struct packed {
    logic               load;
    logic [COLOR_W-1:0] color;
    logic               playing;
  } show_t;

  function automatic logic [DUTY_W-1:0] duty_of(input logic [DUTY_W-1:0] chan,
                                                input logic invert);
    return invert ? DUTY_MAX - chan : chan;
  endfunction

endpackage

FILE: hdl/rgbsp_if.sv
interface rgbsp_in_if import rgbsp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [IDX_W-1:0]   entry_index;
  logic [COLOR_W-1:0] entry_color;
  logic [DUR_W-1:0]   entry_duration;
  logic [LEN_W-1:0]   seq_length;
  logic [REP_W-1:0]   repeat_mode;

  modport source (output valid, cmd, entry_index, entry_color, entry_duration,
                  seq_length, repeat_mode, input ready);
  modport sink   (input valid, cmd, entry_index, entry_color, entry_duration,
                  seq_length, repeat_mode, output ready);
endinterface

interface rgbsp_out_if import rgbsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] red_duty;
  logic [DUTY_W-1:0] green_duty;
  logic [DUTY_W-1:0] blue_duty;
  logic              playing;

  modport source (output valid, red_duty, green_duty, blue_duty, playing, input ready);
  modport sink   (input valid, red_duty, green_duty, blue_duty, playing, output ready);
endinterface

FILE: hdl/rgb_color_sequence_player.sv
// Channel   Dir  Handshake        Word
// in_word   in   valid/ready      cmd, entry_index, entry_color, entry_duration,
//                                 seq_length, repeat_mode
// out_word  out  valid/ready      red_duty, green_duty, blue_duty, playing
// cfg       in   APB (pready=1)   common_anode at byte address 0
//
// One word at a time. Write-entry, solid color and idle ticks pass through DONE;
// start with a nonzero length passes through LOAD0 (read of entry 0) and DONE.
// A running tick walks the table one entry per cycle through the single read port,
// then DONE, or LOAD0 and DONE when the pass wraps back to entry 0 (seq_length capped at TABLE_DEPTH).
// Reset (rst_n low, synchronous) clears control state but not the table.
// A stalled out_word holds its word; the next in_word is accepted but waits in DONE until it drains.
module rgb_color_sequence_player import rgbsp_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  rgbsp_in_if.sink          in_word,
  rgbsp_out_if.source       out_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int ENT_W = COLOR_W + DUR_W;

  // config register
  logic ca_r;

  assign pready = 1'b1;
  assign prdata = (psel && paddr[2] == REG_COMMON_ANODE) ? {{(CFG_DW-1){1'b0}}, ca_r}
                                                        : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_COMMON_ANODE) begin
      ca_r <= pwdata[0];
    end
  end

  // entry table: {color, duration}, one write and one registered read port
  logic [ENT_W-1:0]   mem [TABLE_DEPTH];
  logic               we;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [ENT_W-1:0]   rd_data_r;
  logic [COLOR_W-1:0] rd_color;
  logic [DUR_W-1:0]   rd_dur;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= {in_word.entry_color, in_word.entry_duration};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_color = rd_data_r[ENT_W-1:DUR_W];
  assign rd_dur   = rd_data_r[DUR_W-1:0];
  assign wr_addr  = AW'(in_word.entry_index);

  // sequencer state
  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   cur_r, cur_nxt;
  logic [COLOR_W-1:0] shown_r, shown_nxt;
  logic [DUR_W-1:0]   elapsed_r, elapsed_nxt;
  logic [REP_W-1:0]   rep_r, rep_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               running_r, running_nxt;
  logic [LEN_W-1:0]   idx_r, idx_nxt;
  logic [DUR_W-1:0]   sum_r, sum_nxt;

  logic               accept;
  cmd_t               cmd;
  logic [LEN_W-1:0]   len_sat;
  logic [DUR_W-1:0]   sum_add;
  logic               hit;
  logic               last;
  logic               out_free;
  show_t              show;

  assign accept   = in_word.valid && in_word.ready;
  assign cmd      = cmd_t'(in_word.cmd);
  assign len_sat  = (int'(in_word.seq_length) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH)
                                                            : in_word.seq_length;
  assign sum_add  = sum_r + rd_dur;
  assign hit      = elapsed_r <= sum_add;
  assign last     = (idx_r + LEN_W'(1)) == len_r;
  assign in_word.ready = (state_r == ST_IDLE);

  // walk reads run one entry ahead; every other read wants entry 0
  assign rd_addr = (state_r == ST_WALK && !hit && !last) ? AW'(idx_r + LEN_W'(1)) : '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_TICK:  state_nxt = running_r ? ST_WALK : ST_DONE;
            CMD_START: state_nxt = (len_sat != '0) ? ST_LOAD0 : ST_DONE;
            CMD_WRITE: state_nxt = ST_DONE;
            CMD_SOLID: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_WALK: begin
        priority if (hit) begin
          state_nxt = ST_DONE;
        end else if (last) begin
          state_nxt = (rep_r == REP_W'(1)) ? ST_DONE : ST_LOAD0;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_LOAD0: state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_nxt     = cur_r;
    shown_nxt   = shown_r;
    elapsed_nxt = elapsed_r;
    rep_nxt     = rep_r;
    len_nxt     = len_r;
    running_nxt = running_r;
    idx_nxt     = idx_r;
    sum_nxt     = sum_r;
    we          = 1'b0;
    show        = '{load: 1'b0, color: shown_r, playing: running_r};
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_TICK: begin
              if (running_r) begin
                elapsed_nxt = elapsed_r + DUR_W'(1);
                idx_nxt     = '0;
                sum_nxt     = '0;
              end
            end
            CMD_WRITE: we = int'(in_word.entry_index) < TABLE_DEPTH;
            CMD_START: begin
              len_nxt     = len_sat;
              rep_nxt     = in_word.repeat_mode;
              cur_nxt     = '0;
              elapsed_nxt = '0;
              running_nxt = (len_sat != '0);
              if (len_sat == '0) shown_nxt = '0;
            end
            CMD_SOLID: begin
              running_nxt = 1'b0;
              shown_nxt   = in_word.entry_color;
            end
          endcase
        end
      end
      ST_WALK: begin
        priority if (hit) begin
          // entry found; if it is the shown one, nothing but the elapsed time moves
          if (idx_r != cur_r) begin
            cur_nxt   = idx_r;
            shown_nxt = rd_color;
          end
        end else if (last) begin
          // end of pass
          elapsed_nxt = '0;
          if (rep_r == REP_W'(1)) begin
            running_nxt = 1'b0;
            shown_nxt   = '0;
          end else begin
            if (rep_r > REP_W'(1)) rep_nxt = rep_r - REP_W'(1);
            cur_nxt = '0;
          end
        end else begin
          idx_nxt = idx_r + LEN_W'(1);
          sum_nxt = sum_add;
        end
      end
      ST_LOAD0: shown_nxt = rd_color;
      ST_DONE:  show.load = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cur_r     <= '0;
      shown_r   <= '0;
      elapsed_r <= '0;
      rep_r     <= '0;
      len_r     <= '0;
      running_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_r     <= cur_nxt;
      shown_r   <= shown_nxt;
      elapsed_r <= elapsed_nxt;
      rep_r     <= rep_nxt;
      len_r     <= len_nxt;
      running_r <= running_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    sum_r <= sum_nxt;
  end

  rgbsp_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .show     (show),
    .invert   (ca_r),
    .free     (out_free),
    .out_word (out_word)
  );

endmodule

FILE: hdl/rgbsp_out_stage.sv
module rgbsp_out_stage import rgbsp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  show_t        show,
  input  logic         invert,
  output logic         free,
  rgbsp_out_if.source  out_word
);

  logic              valid_r;
  logic [DUTY_W-1:0] red_r;
  logic [DUTY_W-1:0] green_r;
  logic [DUTY_W-1:0] blue_r;
  logic              playing_r;

  assign free = !valid_r || out_word.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (show.load) begin
      valid_r <= 1'b1;
    end else if (out_word.ready) begin
      valid_r <= 1'b0;
    end
  end

  // polarity set at load; user changes config only while idle; unenforced
  always_ff @(posedge clk) begin
    if (show.load) begin
      red_r     <= duty_of(show.color[23:16], invert);
      green_r   <= duty_of(show.color[15:8], invert);
      blue_r    <= duty_of(show.color[7:0], invert);
      playing_r <= show.playing;
    end
  end

  assign out_word.valid      = valid_r;
  assign out_word.red_duty   = red_r;
  assign out_word.green_duty = green_r;
  assign out_word.blue_duty  = blue_r;
  assign out_word.playing    = playing_r;

endmodule

FILE: hdl/rgbsp_checker.sv
module rgbsp_checker import rgbsp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DUTY_W-1:0] out_red_duty,
  input logic [DUTY_W-1:0] out_green_duty,
  input logic [DUTY_W-1:0] out_blue_duty,
  input logic              out_playing
);

  // one word in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_red_duty) && $stable(out_green_duty)
                                && $stable(out_blue_duty) && $stable(out_playing))
    else $error("result changed while stalled");

endmodule

bind rgb_color_sequence_player rgbsp_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_word.valid),
  .in_ready       (in_word.ready),
  .out_valid      (out_word.valid),
  .out_ready      (out_word.ready),
  .out_red_duty   (out_word.red_duty),
  .out_green_duty (out_word.green_duty),
  .out_blue_duty  (out_word.blue_duty),
  .out_playing    (out_word.playing)
);
